// File: rtl/core/port_forward_table_wrr_macros.svh
// ----------------------------------------------------------------------------
// port forward table assertion macros
// shared assertion forms for the port forward table checker
// ----------------------------------------------------------------------------
`ifndef PORT_FORWARD_TABLE_WRR_MACROS_SVH
`define PORT_FORWARD_TABLE_WRR_MACROS_SVH

// same-cycle implication
`define PFTW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define PFTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/core/pftw_pkg.sv
// ----------------------------------------------------------------------------
// pftw_pkg
// types and codes shared by the port forward table modules
// ----------------------------------------------------------------------------
package pftw_pkg;

    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_DELETE  = 3'd1;
    localparam logic [2:0] KIND_FLUSH   = 3'd2;
    localparam logic [2:0] KIND_PROBE   = 3'd3;
    localparam logic [2:0] KIND_FORWARD = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic CFG_PORT_MIN = 1'b0;
    localparam logic CFG_PORT_MAX = 1'b1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         protocol;
        logic [15:0]        local_port;
        logic [31:0]        local_addr;
        logic [15:0]        remote_port;
        logic [31:0]        remote_addr;
        logic signed [15:0] weight;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [31:0] target_addr;
        logic [15:0] target_port;
    } t_result;

    typedef struct packed {
        logic       load_item;
        logic       calc_match;
        logic       add_edit;
        logic       add_insert;
        logic       del_pick;
        logic       del_apply;
        logic       flush;
        logic       scan_clear;
        logic       scan_step;
        logic       fwd_update;
        logic       res_set;
        logic       res_hit;
        logic [1:0] res_status;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       chk_ok;
        logic       weight_ok;
        logic       any_match;
        logic       free_found;
        logic       del_left;
        logic       scan_last;
        logic       best_found;
        logic       multi;
        logic       out_free;
    } t_sts;

endpackage

// File: rtl/core/pftw_ctrl.sv
// ----------------------------------------------------------------------------
// pftw_ctrl
// sequencer for table edits, deletes, lookups and result handoff
// ----------------------------------------------------------------------------
module pftw_ctrl import pftw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_MATCH     = 8'b0000_0010,
        ST_DECIDE    = 8'b0000_0100,
        ST_DEL_PICK  = 8'b0000_1000,
        ST_DEL_APPLY = 8'b0001_0000,
        ST_SCAN      = 8'b0010_0000,
        ST_SCAN_END  = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_MATCH;
                end
            end
            ST_MATCH: begin
                o_cmd.calc_match = 1'b1;
                n_state          = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.res_set = 1'b1;
                n_state       = ST_DONE;
                case (i_sts.kind)
                    KIND_ADD: begin
                        if (!i_sts.chk_ok || !i_sts.weight_ok) begin
                            o_cmd.res_status = STATUS_INVALID;
                        end else if (i_sts.any_match) begin
                            o_cmd.add_edit   = 1'b1;
                            o_cmd.res_status = STATUS_OK;
                        end else if (!i_sts.free_found) begin
                            o_cmd.res_status = STATUS_FULL;
                        end else begin
                            o_cmd.add_insert = 1'b1;
                            o_cmd.res_status = STATUS_OK;
                        end
                    end
                    KIND_DELETE: begin
                        if (!i_sts.chk_ok) begin
                            o_cmd.res_status = STATUS_INVALID;
                        end else if (!i_sts.any_match) begin
                            o_cmd.res_status = STATUS_NOTFOUND;
                        end else begin
                            o_cmd.res_status = STATUS_OK;
                            n_state          = ST_DEL_PICK;
                        end
                    end
                    KIND_FLUSH: begin
                        o_cmd.flush      = 1'b1;
                        o_cmd.res_status = STATUS_OK;
                    end
                    KIND_PROBE, KIND_FORWARD: begin
                        o_cmd.res_set    = 1'b0;
                        o_cmd.scan_clear = 1'b1;
                        n_state          = ST_SCAN;
                    end
                    default: begin
                        o_cmd.res_status = STATUS_INVALID;
                    end
                endcase
            end
            ST_DEL_PICK: begin
                o_cmd.del_pick = 1'b1;
                n_state        = ST_DEL_APPLY;
            end
            ST_DEL_APPLY: begin
                o_cmd.del_apply = 1'b1;
                n_state         = i_sts.del_left ? ST_DEL_PICK : ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                o_cmd.res_set = 1'b1;
                n_state       = ST_DONE;
                if (!i_sts.best_found) begin
                    o_cmd.res_status = STATUS_NOTFOUND;
                end else begin
                    o_cmd.res_status = STATUS_OK;
                    o_cmd.res_hit    = 1'b1;
                    if (i_sts.kind == KIND_FORWARD && i_sts.multi) begin
                        o_cmd.fwd_update = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pftw_dp.sv
// ----------------------------------------------------------------------------
// pftw_dp
// slot storage, parallel match, list ordering and result registers
// ----------------------------------------------------------------------------
module pftw_dp import pftw_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_in_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_result
);

    localparam int IDXW = $clog2(ENTRIES);
    localparam int CNTW = $clog2(ENTRIES + 1);

    logic [15:0] r_port_min;
    logic [15:0] r_port_max;
    t_item       r_item;

    logic              r_valid [ENTRIES];
    logic              r_tcp   [ENTRIES];
    logic [15:0]       r_lport [ENTRIES];
    logic [31:0]       r_laddr [ENTRIES];
    logic [15:0]       r_rport [ENTRIES];
    logic [31:0]       r_raddr [ENTRIES];
    logic [14:0]       r_wt    [ENTRIES];
    logic [14:0]       r_cr    [ENTRIES];
    logic [IDXW-1:0]   r_rank  [ENTRIES];

    logic [CNTW-1:0]   r_cnt_tcp;
    logic [CNTW-1:0]   r_cnt_udp;

    logic [ENTRIES-1:0] r_rel_vec;
    logic [ENTRIES-1:0] r_ex_vec;
    logic [IDXW-1:0]    r_free_idx;
    logic               r_free_found;

    logic [IDXW-1:0]    r_sel_idx;
    logic [IDXW-1:0]    r_sel_rank;
    logic               r_sel_tcp;
    logic [IDXW-1:0]    r_scan_idx;
    logic               r_best_found;

    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic               item_tcp;
    logic [ENTRIES-1:0] rel_c;
    logic [ENTRIES-1:0] ex_c;
    logic [ENTRIES-1:0] gap_dec;
    logic [IDXW-1:0]    free_idx_c;
    logic               free_any_c;
    logic [IDXW-1:0]    pick_idx;
    logic [CNTW-1:0]    sel_len;
    logic [CNTW-1:0]    len_m1;
    logic               rotate;
    logic [14:0]        w15;

    assign item_tcp = (r_item.protocol == PROTO_TCP);
    assign w15      = r_item.weight[14:0];
    assign sel_len  = r_sel_tcp ? r_cnt_tcp : r_cnt_udp;
    assign len_m1   = sel_len - CNTW'(1);
    assign rotate   = (r_cr[r_sel_idx] <= 15'd1);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            logic base;
            base = r_valid[i] && (r_tcp[i] == item_tcp) &&
                   (r_lport[i] == r_item.local_port);
            rel_c[i] = base &&
                       (r_item.local_addr == '0 || r_laddr[i] == r_item.local_addr) &&
                       (r_item.remote_port == '0 || r_rport[i] == r_item.remote_port) &&
                       (r_item.remote_addr == '0 || r_raddr[i] == r_item.remote_addr);
            ex_c[i]  = base && (r_laddr[i] == r_item.local_addr);
            gap_dec[i] = (IDXW'(i) != r_sel_idx) && r_valid[i] &&
                         (r_tcp[i] == r_sel_tcp) && (r_rank[i] > r_sel_rank);
        end
    end

    always_comb begin
        free_idx_c = '0;
        free_any_c = 1'b0;
        pick_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx_c = IDXW'(i);
                free_any_c = 1'b1;
            end
            if (r_rel_vec[i]) begin
                pick_idx = IDXW'(i);
            end
        end
    end

    always_comb begin
        o_sts.free_found = r_free_found;
        o_sts.kind       = r_item.kind;
        o_sts.chk_ok     = (r_item.local_port >= r_port_min) &&
                           (r_item.local_port <= r_port_max) &&
                           (r_item.protocol == PROTO_TCP || r_item.protocol == PROTO_UDP);
        o_sts.weight_ok  = !r_item.weight[15] && (r_item.weight != 16'sd0);
        o_sts.any_match  = |r_rel_vec;
        o_sts.del_left   = |r_rel_vec;
        o_sts.scan_last  = (r_scan_idx == IDXW'(ENTRIES - 1));
        o_sts.best_found = r_best_found;
        o_sts.multi      = ({1'b0, r_cnt_tcp} + {1'b0, r_cnt_udp}) > (CNTW + 1)'(1);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // config, counts, valid bits and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_min  <= 16'd1;
            r_port_max  <= 16'hFFFF;
            r_cnt_tcp   <= '0;
            r_cnt_udp   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PORT_MIN) begin
                    r_port_min <= i_cfg_data;
                end else begin
                    r_port_max <= i_cfg_data;
                end
            end
            if (i_cmd.flush) begin
                r_cnt_tcp <= '0;
                r_cnt_udp <= '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (i_cmd.add_insert) begin
                r_valid[r_free_idx] <= 1'b1;
                if (item_tcp) begin
                    r_cnt_tcp <= r_cnt_tcp + CNTW'(1);
                end else begin
                    r_cnt_udp <= r_cnt_udp + CNTW'(1);
                end
            end
            if (i_cmd.del_apply) begin
                r_valid[r_sel_idx] <= 1'b0;
                if (r_sel_tcp) begin
                    r_cnt_tcp <= r_cnt_tcp - CNTW'(1);
                end else begin
                    r_cnt_udp <= r_cnt_udp - CNTW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.calc_match) begin
            r_rel_vec    <= rel_c;
            r_ex_vec     <= ex_c;
            r_free_idx   <= free_idx_c;
            r_free_found <= free_any_c;
        end
        if (i_cmd.del_pick) begin
            r_sel_idx           <= pick_idx;
            r_sel_rank          <= r_rank[pick_idx];
            r_sel_tcp           <= r_tcp[pick_idx];
            r_rel_vec[pick_idx] <= 1'b0;
        end
        if (i_cmd.scan_clear) begin
            r_scan_idx   <= '0;
            r_best_found <= 1'b0;
            r_sel_tcp    <= item_tcp;
        end
        if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDXW'(1);
            if (r_ex_vec[r_scan_idx] &&
                (!r_best_found || r_rank[r_scan_idx] < r_sel_rank)) begin
                r_sel_idx    <= r_scan_idx;
                r_sel_rank   <= r_rank[r_scan_idx];
                r_best_found <= 1'b1;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.add_edit && r_rel_vec[i]) begin
                r_wt[i] <= w15;
                r_cr[i] <= w15;
            end
            if (i_cmd.add_insert) begin
                if (IDXW'(i) == r_free_idx) begin
                    r_tcp[i]   <= item_tcp;
                    r_lport[i] <= r_item.local_port;
                    r_laddr[i] <= r_item.local_addr;
                    r_rport[i] <= r_item.remote_port;
                    r_raddr[i] <= r_item.remote_addr;
                    r_wt[i]    <= w15;
                    r_cr[i]    <= w15;
                    r_rank[i]  <= '0;
                end else if (r_valid[i] && r_tcp[i] == item_tcp) begin
                    r_rank[i] <= r_rank[i] + IDXW'(1);
                end
            end
            if (i_cmd.del_apply && gap_dec[i]) begin
                r_rank[i] <= r_rank[i] - IDXW'(1);
            end
            if (i_cmd.fwd_update) begin
                if (IDXW'(i) == r_sel_idx) begin
                    if (rotate) begin
                        r_cr[i]   <= r_wt[i];
                        r_rank[i] <= len_m1[IDXW-1:0];
                    end else begin
                        r_cr[i] <= r_cr[i] - 15'd1;
                    end
                end else if (rotate && gap_dec[i]) begin
                    r_rank[i] <= r_rank[i] - IDXW'(1);
                end
            end
        end
        if (i_cmd.res_set) begin
            r_res.status      <= i_cmd.res_status;
            r_res.hit         <= i_cmd.res_hit;
            r_res.target_addr <= i_cmd.res_hit ? r_raddr[r_sel_idx] : 32'd0;
            r_res.target_port <= i_cmd.res_hit ? r_rport[r_sel_idx] : 16'd0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule

// File: rtl/core/port_forward_table_wrr.sv
// ----------------------------------------------------------------------------
// port_forward_table_wrr
// port forwarding table with per-protocol ordered lists and weighted rotation
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        input      i_in_valid, o_in_stall, i_in_item
// out       output     o_out_valid, i_out_stall, o_out_result
// cfg       input      i_cfg_we, i_cfg_idx, i_cfg_data
//
// add, flush and invalid items pass through match and decide, then hand off the result
// delete repeats one pick and one reorder step for each removed entry
// probe and forward run a slot-by-slot rank scan over every entry
// one item at a time; the result register frees the input while it waits
// sync active-low reset clears valid bits, list counts and out valid registers
// ----------------------------------------------------------------------------
module port_forward_table_wrr import pftw_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_item       i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    pftw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pftw_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_item    (i_in_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

endmodule

// File: rtl/core/pftw_checker.sv
// ----------------------------------------------------------------------------
// pftw_checker
// port-level checks for the port forward table
// ----------------------------------------------------------------------------
`include "port_forward_table_wrr_macros.svh"

module pftw_checker import pftw_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_result o_out_result
);

    // stalled result holds
    `PFTW_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_result))

    // a hit is always ok
    `PFTW_ASSERT_NOW(a_hit_ok, o_out_valid && o_out_result.hit, o_out_result.status == STATUS_OK)

    // no target without a hit
    `PFTW_ASSERT_NOW(a_miss_zero, o_out_valid && !o_out_result.hit, o_out_result.target_addr == 32'd0 && o_out_result.target_port == 16'd0)

    // one item at a time
    `PFTW_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind port_forward_table_wrr pftw_checker u_pftw_checker (.*);
